>>> hdl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types and constants of the minutiae template parser.
// ----------------------------------------------------------------------------
package mtp_pkg;

  // width of the template length and the remaining byte count
  localparam int LENGTH_BITS = 16;

  typedef logic [LENGTH_BITS-1:0] len_t;

  // record kinds
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_VIEW    = 3'd1;
  localparam logic [2:0] KIND_MINUTIA = 3'd2;
  localparam logic [2:0] KIND_EXT     = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_FORMAT     = 4'd1;
  localparam logic [3:0] ERR_VERSION    = 4'd2;
  localparam logic [3:0] ERR_LENGTH     = 4'd3;
  localparam logic [3:0] ERR_RESERVED   = 4'd4;
  localparam logic [3:0] ERR_POSITION   = 4'd5;
  localparam logic [3:0] ERR_IMPRESSION = 4'd6;
  localparam logic [3:0] ERR_QUALITY    = 4'd7;
  localparam logic [3:0] ERR_TYPE       = 4'd8;
  localparam logic [3:0] ERR_TRUNCATED  = 4'd9;

  // template layout
  localparam int HEADER_BYTES  = 24;
  localparam int VIEW_BYTES    = 4;
  localparam int MINUTIA_BYTES = 6;
  localparam int EXT_BYTES     = 2;

  localparam logic [31:0] TEMPLATE_MAGIC = 32'h464d5200;
  localparam logic [31:0] VERSION_ID     = 32'h20323000;
  localparam logic [15:0] COORD_MASK     = 16'h3fff;
  localparam logic [7:0]  POSITION_LIMIT = 8'd11;
  localparam logic [3:0]  IMPRESS_LIMIT  = 4'd9;
  localparam logic [7:0]  QUALITY_MAX    = 8'd100;
  localparam logic [1:0]  TYPE_INVALID   = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  code;
    logic [7:0]  view_idx;
    logic [7:0]  min_idx;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic [15:0] e;
    logic [7:0]  f;
    logic        done;
    logic        last;
  } result_t;

  function automatic result_t make_rec(
    input logic [2:0]  kind,
    input logic [3:0]  code,
    input logic [7:0]  view_idx,
    input logic [7:0]  min_idx,
    input logic [15:0] a,
    input logic [15:0] b,
    input logic [15:0] c,
    input logic [15:0] d,
    input logic [15:0] e,
    input logic [7:0]  f
  );
    result_t r;
    r.kind     = kind;
    r.code     = code;
    r.view_idx = view_idx;
    r.min_idx  = min_idx;
    r.a        = a;
    r.b        = b;
    r.c        = c;
    r.d        = d;
    r.e        = e;
    r.f        = f;
    r.done     = 1'b0;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic result_t make_err(
    input logic [3:0] code,
    input logic [7:0] view_idx,
    input logic [7:0] min_idx
  );
    return make_rec(KIND_ERROR, code, view_idx, min_idx,
                    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
  endfunction

endpackage

>>> hdl/mtp_parser.sv
// ----------------------------------------------------------------------------
// mtp_parser
// Parser state and the per-byte step: collects record bytes, checks each
// completed record and produces up to two results for the byte.
// ----------------------------------------------------------------------------
module mtp_parser import mtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic        start_flag,
  input  logic [7:0]  data_byte,
  input  logic [15:0] template_length,
  output logic [1:0]  push_count,
  output result_t     res0,
  output result_t     res1
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_VIEW    = 3'd2;
  localparam logic [2:0] PH_MINUTIA = 3'd3;
  localparam logic [2:0] PH_EXT     = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [4:0]  byte_idx, byte_idx_next;
  len_t        rem, rem_next;
  len_t        skip, skip_next;
  logic [7:0]  views_total, views_total_next;
  logic [7:0]  view_cnt, view_cnt_next;
  logic [7:0]  min_total, min_total_next;
  logic [7:0]  min_cnt, min_cnt_next;

  logic [7:0]  buffer [HEADER_BYTES];
  logic [7:0]  rec [HEADER_BYTES];
  logic [4:0]  wr_idx;
  logic        buf_wr;
  logic [4:0]  need_len;

  result_t     res [2];
  logic [1:0]  n;
  logic        ended;

  logic [31:0] hdr_word;
  logic [15:0] word0;
  logic [15:0] word1;
  logic [1:0]  mtype;

  // record bytes as seen at the end of this byte: buffer plus current byte
  assign wr_idx = start_flag ? 5'd0 : byte_idx;

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      rec[i] = (wr_idx == 5'(i)) ? data_byte : buffer[i];
    end
  end

  assign hdr_word = {rec[8], rec[9], rec[10], rec[11]};
  assign word0    = {rec[0], rec[1]};
  assign word1    = {rec[2], rec[3]};
  assign mtype    = word0[15:14];

  always_comb begin
    phase_next       = phase;
    byte_idx_next    = byte_idx;
    rem_next         = rem;
    skip_next        = skip;
    views_total_next = views_total;
    view_cnt_next    = view_cnt;
    min_total_next   = min_total;
    min_cnt_next     = min_cnt;
    res[0]           = '0;
    res[1]           = '0;
    n                = 2'd0;
    ended            = 1'b0;
    buf_wr           = 1'b0;
    need_len         = 5'd0;

    if (start_flag) begin
      phase_next       = PH_HEADER;
      byte_idx_next    = 5'd0;
      rem_next         = len_t'(template_length);
      skip_next        = '0;
      views_total_next = 8'd0;
      view_cnt_next    = 8'd0;
      min_total_next   = 8'd0;
      min_cnt_next     = 8'd0;
      if (rem_next < len_t'(HEADER_BYTES)) begin
        res[n[0]]  = make_err(ERR_TRUNCATED, view_cnt_next, min_cnt_next);
        n          = n + 2'd1;
        phase_next = PH_IDLE;
        ended      = 1'b1;
      end
    end

    if (phase_next == PH_SKIP) begin
      skip_next = skip_next - len_t'(1);
      if (skip_next == '0) begin
        view_cnt_next = view_cnt_next + 8'd1;
        min_cnt_next  = 8'd0;
        phase_next    = PH_VIEW;
        if (rem_next < len_t'(VIEW_BYTES)) begin
          res[n[0]]  = make_err(ERR_TRUNCATED, view_cnt_next, min_cnt_next);
          n          = n + 2'd1;
          phase_next = PH_IDLE;
          ended      = 1'b1;
        end
      end
    end else if (phase_next != PH_IDLE) begin
      unique case (phase_next)
        PH_HEADER:  need_len = 5'(HEADER_BYTES);
        PH_VIEW:    need_len = 5'(VIEW_BYTES);
        PH_MINUTIA: need_len = 5'(MINUTIA_BYTES);
        default:    need_len = 5'(EXT_BYTES);
      endcase
      buf_wr        = 1'b1;
      byte_idx_next = wr_idx + 5'd1;
      if (byte_idx_next >= need_len) begin
        byte_idx_next = 5'd0;
        unique case (phase_next)
          PH_HEADER: begin
            if ({rec[0], rec[1], rec[2], rec[3]} != TEMPLATE_MAGIC) begin
              res[n[0]] = make_err(ERR_FORMAT, view_cnt_next, min_cnt_next);
              n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
            end else if ({rec[4], rec[5], rec[6], rec[7]} != VERSION_ID) begin
              res[n[0]] = make_err(ERR_VERSION, view_cnt_next, min_cnt_next);
              n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
            end else if (hdr_word != 32'(rem_next)) begin
              res[n[0]] = make_err(ERR_LENGTH, view_cnt_next, min_cnt_next);
              n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
            end else if (rec[23] != 8'd0) begin
              res[n[0]] = make_err(ERR_RESERVED, view_cnt_next, min_cnt_next);
              n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
            end else begin
              res[n[0]] = make_rec(KIND_HEADER, ERR_NONE, view_cnt_next, min_cnt_next,
                                   {rec[14], rec[15]}, {rec[16], rec[17]},
                                   {rec[18], rec[19]}, {rec[20], rec[21]},
                                   {rec[12], rec[13]}, rec[22]);
              n                = n + 2'd1;
              rem_next         = rem_next - len_t'(HEADER_BYTES);
              views_total_next = rec[22];
              view_cnt_next    = 8'd0;
              min_cnt_next     = 8'd0;
              if (views_total_next == 8'd0) begin
                phase_next = PH_IDLE;
                ended      = 1'b1;
              end else begin
                phase_next = PH_VIEW;
                if (rem_next < len_t'(VIEW_BYTES)) begin
                  res[n[0]] = make_err(ERR_TRUNCATED, view_cnt_next, min_cnt_next);
                  n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
                end
              end
            end
          end
          PH_VIEW: begin
            if (rec[0] >= POSITION_LIMIT) begin
              res[n[0]] = make_err(ERR_POSITION, view_cnt_next, min_cnt_next);
              n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
            end else if (rec[1][3:0] >= IMPRESS_LIMIT) begin
              res[n[0]] = make_err(ERR_IMPRESSION, view_cnt_next, min_cnt_next);
              n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
            end else if (rec[2] > QUALITY_MAX) begin
              res[n[0]] = make_err(ERR_QUALITY, view_cnt_next, min_cnt_next);
              n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
            end else begin
              res[n[0]] = make_rec(KIND_VIEW, ERR_NONE, view_cnt_next, min_cnt_next,
                                   16'(rec[0]), 16'(rec[1][7:4]), 16'(rec[1][3:0]),
                                   16'(rec[2]), 16'd0, rec[3]);
              n              = n + 2'd1;
              rem_next       = rem_next - len_t'(VIEW_BYTES);
              min_total_next = rec[3];
              min_cnt_next   = 8'd0;
              if (min_total_next != 8'd0) begin
                phase_next = PH_MINUTIA;
                if (rem_next < len_t'(MINUTIA_BYTES)) begin
                  res[n[0]] = make_err(ERR_TRUNCATED, view_cnt_next, min_cnt_next);
                  n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
                end
              end else begin
                phase_next = PH_EXT;
                if (rem_next < len_t'(EXT_BYTES)) begin
                  res[n[0]] = make_err(ERR_TRUNCATED, view_cnt_next, min_cnt_next);
                  n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
                end
              end
            end
          end
          PH_MINUTIA: begin
            if (mtype == TYPE_INVALID) begin
              res[n[0]] = make_err(ERR_TYPE, view_cnt_next, min_cnt_next);
              n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
            end else begin
              res[n[0]] = make_rec(KIND_MINUTIA, ERR_NONE, view_cnt_next, min_cnt_next,
                                   word0 & COORD_MASK, word1 & COORD_MASK,
                                   16'(rec[4]), 16'(mtype), 16'd0, rec[5]);
              n            = n + 2'd1;
              rem_next     = rem_next - len_t'(MINUTIA_BYTES);
              min_cnt_next = min_cnt_next + 8'd1;
              if (min_cnt_next < min_total_next) begin
                if (rem_next < len_t'(MINUTIA_BYTES)) begin
                  res[n[0]] = make_err(ERR_TRUNCATED, view_cnt_next, min_cnt_next);
                  n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
                end
              end else begin
                phase_next = PH_EXT;
                if (rem_next < len_t'(EXT_BYTES)) begin
                  res[n[0]] = make_err(ERR_TRUNCATED, view_cnt_next, min_cnt_next);
                  n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
                end
              end
            end
          end
          default: begin
            res[n[0]] = make_rec(KIND_EXT, ERR_NONE, view_cnt_next, min_cnt_next,
                                 word0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
            n        = n + 2'd1;
            rem_next = rem_next - len_t'(EXT_BYTES);
            if (32'(word0) > 32'(rem_next)) begin
              res[n[0]] = make_err(ERR_TRUNCATED, view_cnt_next, min_cnt_next);
              n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
            end else if ({1'b0, view_cnt_next} + 9'd1 >= {1'b0, views_total_next}) begin
              // last view done, its extended data is not read
              phase_next = PH_IDLE;
              ended      = 1'b1;
            end else if (word0 == 16'd0) begin
              view_cnt_next = view_cnt_next + 8'd1;
              min_cnt_next  = 8'd0;
              phase_next    = PH_VIEW;
              if (rem_next < len_t'(VIEW_BYTES)) begin
                res[n[0]] = make_err(ERR_TRUNCATED, view_cnt_next, min_cnt_next);
                n = n + 2'd1; phase_next = PH_IDLE; ended = 1'b1;
              end
            end else begin
              skip_next  = len_t'(word0);
              rem_next   = rem_next - len_t'(word0);
              phase_next = PH_SKIP;
            end
          end
        endcase
      end
    end

    // mark the final result of this byte
    if (n == 2'd1) begin
      res[0].last = 1'b1;
      res[0].done = ended;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
      res[1].done = ended;
    end
  end

  assign push_count = go ? n : 2'd0;
  assign res0       = res[0];
  assign res1       = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      byte_idx    <= 5'd0;
      rem         <= '0;
      skip        <= '0;
      views_total <= 8'd0;
      view_cnt    <= 8'd0;
      min_total   <= 8'd0;
      min_cnt     <= 8'd0;
    end else if (go) begin
      phase       <= phase_next;
      byte_idx    <= byte_idx_next;
      rem         <= rem_next;
      skip        <= skip_next;
      views_total <= views_total_next;
      view_cnt    <= view_cnt_next;
      min_total   <= min_total_next;
      min_cnt     <= min_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && buf_wr) begin
      buffer[wr_idx] <= data_byte;
    end
  end

endmodule

>>> hdl/mtp_result_fifo.sv
// ----------------------------------------------------------------------------
// mtp_result_fifo
// Four-entry result queue: takes up to two results a cycle, hands out one while the output is not stalled.
// ----------------------------------------------------------------------------
module mtp_result_fifo import mtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  output logic       room2,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    head
);

  localparam int DEPTH = 4;

  result_t    mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rd_ptr];
  // room for two more once this cycle's pop is counted
  assign room2     = (count <= 3'(DEPTH - 2)) || ((count == 3'(DEPTH - 1)) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(push_count) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push1;
    end
  end

endmodule

>>> hdl/minutiae_template_parser_top.sv
// ----------------------------------------------------------------------------
// minutiae_template_parser_top
// Streaming parser for big-endian fingerprint minutiae templates.
// ----------------------------------------------------------------------------
// Takes one template byte per item and can accept an item every cycle. Each
// byte goes into an input register, from which it is parsed by a
// single combinational step that yields zero, one or two result items
// (header, view, minutia, extended length or error records). Results wait in
// a four-entry queue and leave one per cycle unless the output stalls; with
// an empty queue the first result of a byte passes through the input
// register and the queue memory to the output. The input stalls only when
// the queue cannot take two more results, so a sink that keeps up sees a
// sustained rate of one byte per cycle. There is no clearing pass after reset.
module minutiae_template_parser_top import mtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_flag,
  input  logic [7:0]  data_byte,
  input  logic [15:0] template_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  record_kind,
  output logic [3:0]  error_code,
  output logic [7:0]  view_index,
  output logic [7:0]  minutia_index,
  output logic [15:0] word_a,
  output logic [15:0] word_b,
  output logic [15:0] word_c,
  output logic [15:0] word_d,
  output logic [15:0] word_e,
  output logic [7:0]  word_f,
  output logic        decode_done,
  output logic        run_last
);

  logic        in_full;
  logic        in_start;
  logic [7:0]  in_byte;
  logic [15:0] in_length;
  logic        go;
  logic        room2;
  logic [1:0]  push_count;
  result_t     res0;
  result_t     res1;
  result_t     head;

  assign go       = in_full && room2;
  assign in_stall = in_full && !room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_start  <= start_flag;
      in_byte   <= data_byte;
      in_length <= template_length;
    end
  end

  mtp_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .start_flag      (in_start),
    .data_byte       (in_byte),
    .template_length (in_length),
    .push_count      (push_count),
    .res0            (res0),
    .res1            (res1)
  );

  mtp_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .room2      (room2),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head       (head)
  );

  assign record_kind   = head.kind;
  assign error_code    = head.code;
  assign view_index    = head.view_idx;
  assign minutia_index = head.min_idx;
  assign word_a        = head.a;
  assign word_b        = head.b;
  assign word_c        = head.c;
  assign word_d        = head.d;
  assign word_e        = head.e;
  assign word_f        = head.f;
  assign decode_done   = head.done;
  assign run_last      = head.last;

endmodule
